// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Depends on signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("deframer assertion failed");
`define PSD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("deframer forbidden condition seen");
`else
`define PSD_ASSERT(lbl, prop)
`define PSD_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/psd_pkg.sv =====
// Shared types and constants for the packet stream deframer.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps
package psd_pkg;

  localparam int unsigned LenW  = 10;
  localparam int unsigned SeqW  = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned EvW   = 2;

  localparam logic [15:0] HdrKeepAlive = 16'h0C00;
  localparam logic [15:0] HdrStreamBeg = 16'hC000;
  localparam logic [15:0] HdrStreamEnd = 16'h8000;

  localparam logic [LenW-1:0] MaxPayloadRst = 10'd1022;

  localparam logic [EvW-1:0] EV_DATA  = 2'd0;
  localparam logic [EvW-1:0] EV_BEGIN = 2'd1;
  localparam logic [EvW-1:0] EV_END   = 2'd2;
  localparam logic [EvW-1:0] EV_ERROR = 2'd3;

  typedef enum logic [2:0] {
    PH_LOW  = 3'b001,
    PH_HIGH = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    logic            keep_alive;
    logic            stream_beg;
    logic            stream_end;
    logic            bad;
    logic            forward;
    logic [LenW-1:0] len;
  } hdr_dec_t;

endpackage

// ===== rtl/psd_if.sv =====
// Handshake channels of the deframer: received words in, events out.
// Depends on psd_pkg for field widths.
`timescale 1ns / 1ps
interface psd_in_if import psd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  logic             connection_start;
  modport source (output valid, rx_byte, connection_start, input ready);
  modport sink (input valid, rx_byte, connection_start, output ready);
endinterface

interface psd_out_if import psd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic [EvW-1:0]   event_res;
  logic             last_of_packet;
  modport source (output valid, out_byte, event_res, last_of_packet, input ready);
  modport sink (input valid, out_byte, event_res, last_of_packet, output ready);
endinterface

// ===== rtl/psd_hdr_check.sv =====
// Decodes a complete 16-bit header and checks it against the parser state.
// Depends on psd_pkg for the header constants and the decode struct.
`timescale 1ns / 1ps
module psd_hdr_check import psd_pkg::*; (
  input  logic [ByteW-1:0] header_low,
  input  logic [ByteW-1:0] header_high,
  input  logic [SeqW-1:0]  expected_seq,
  input  logic [LenW-1:0]  max_payload,
  output hdr_dec_t         dec
);

  logic [15:0]     hdr;
  logic [SeqW-1:0] seq;
  logic [1:0]      ptype;

  assign hdr   = {header_high, header_low};
  assign seq   = hdr[15:12];
  assign ptype = hdr[11:10];

  always_comb begin
    dec.keep_alive = (hdr == HdrKeepAlive);
    dec.stream_beg = (hdr == HdrStreamBeg);
    dec.stream_end = (hdr == HdrStreamEnd);
    dec.len        = hdr[LenW-1:0];
    dec.forward    = (ptype == 2'd0);
    dec.bad        = (seq != expected_seq) || (dec.len == '0) || (dec.len > max_payload);
  end

endmodule

// ===== rtl/packet_stream_deframer_top.sv =====
// Top level of the packet stream deframer: input register, parser, result register.
// Depends on psd_pkg, psd_in_if, psd_out_if, psd_hdr_check and assert_macros.svh.
// An accepted word passes the input register, then the parser, then the result register before its event shows.
// Throughput: one word per cycle, held only by back-pressure on the event channel.
// The parser state update over the header compare is combinational, once per word.
// Reset (rst, synchronous): clears parser state and both stages; max_payload goes to 1022.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module packet_stream_deframer_top import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  psd_in_if.sink           bytes,
  psd_out_if.source        events,
  input  logic             cfg_wr_en,
  input  logic [LenW-1:0]  cfg_wr_data
);

  logic [LenW-1:0]  max_payload;

  // Input register.
  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             in_start;

  // Parser state.
  phase_t           phase, phase_next;
  logic [ByteW-1:0] header_low, header_low_next;
  logic [LenW-1:0]  bytes_left, bytes_left_next;
  logic             forward_payload, forward_payload_next;
  logic [SeqW-1:0]  expected_seq, expected_seq_next;
  logic             failed, failed_next;

  // Result register.
  logic             out_valid;
  logic [ByteW-1:0] out_byte;
  logic [EvW-1:0]   out_event;
  logic             out_last;

  logic             res_valid;
  logic [ByteW-1:0] res_byte;
  logic [EvW-1:0]   res_event;
  logic             res_last;
  logic [LenW-1:0]  left_dec;
  logic             advance;
  hdr_dec_t         dec;

  assign advance      = in_valid && (!out_valid || events.ready);
  assign bytes.ready  = !in_valid || advance;

  assign events.valid          = out_valid;
  assign events.out_byte       = out_byte;
  assign events.event_res      = out_event;
  assign events.last_of_packet = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MaxPayloadRst;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      in_byte  <= bytes.rx_byte;
      in_start <= bytes.connection_start;
    end
  end

  psd_hdr_check u_hdr_check (
    .header_low   (header_low),
    .header_high  (in_byte),
    .expected_seq (expected_seq),
    .max_payload  (max_payload),
    .dec          (dec)
  );

  assign left_dec = bytes_left - 1'b1;

  always_comb begin
    phase_next           = phase;
    header_low_next      = header_low;
    bytes_left_next      = bytes_left;
    forward_payload_next = forward_payload;
    expected_seq_next    = expected_seq;
    failed_next          = failed;
    res_valid            = 1'b0;
    res_byte             = '0;
    res_event            = EV_DATA;
    res_last             = 1'b0;
    if (in_start) begin
      phase_next           = PH_LOW;
      header_low_next      = '0;
      bytes_left_next      = '0;
      forward_payload_next = 1'b0;
      expected_seq_next    = '0;
      failed_next          = 1'b0;
    end else if (!failed) begin
      case (phase)
        PH_HIGH: begin
          phase_next = PH_LOW;
          if (dec.keep_alive) begin
            res_valid = 1'b0;
          end else if (dec.stream_beg) begin
            res_valid = 1'b1;
            res_event = EV_BEGIN;
          end else if (dec.stream_end) begin
            res_valid = 1'b1;
            res_event = EV_END;
          end else if (dec.bad) begin
            failed_next = 1'b1;
            res_valid   = 1'b1;
            res_event   = EV_ERROR;
          end else begin
            forward_payload_next = dec.forward;
            if (dec.forward) begin
              expected_seq_next = expected_seq + 1'b1;
            end
            bytes_left_next = dec.len;
            phase_next      = PH_DATA;
          end
        end
        PH_DATA: begin
          bytes_left_next = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_LOW;
          end
          if (forward_payload) begin
            res_valid = 1'b1;
            res_byte  = in_byte;
            res_event = EV_DATA;
            res_last  = (left_dec == '0);
          end
        end
        default: begin
          // An unused phase code behaves as waiting for a header low word.
          header_low_next = in_byte;
          phase_next      = PH_HIGH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LOW;
      header_low      <= '0;
      bytes_left      <= '0;
      forward_payload <= 1'b0;
      expected_seq    <= '0;
      failed          <= 1'b0;
    end else if (advance) begin
      phase           <= phase_next;
      header_low      <= header_low_next;
      bytes_left      <= bytes_left_next;
      forward_payload <= forward_payload_next;
      expected_seq    <= expected_seq_next;
      failed          <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= res_byte;
      out_event <= res_event;
      out_last  <= res_last;
    end
  end

  // Once failed, words other than a connection start give no event.
  `PSD_ASSERT(a_failed_silent, failed && advance && !in_start |=> !out_valid)
  // A connection start always leaves a clean parser behind.
  `PSD_ASSERT(a_start_clears, advance && in_start |=> !failed && expected_seq == '0)
  // A payload phase always has bytes still to come.
  `PSD_NEVER(a_data_nonzero, phase == PH_DATA && bytes_left == '0)
  // The last-of-packet flag only marks payload words.
  `PSD_NEVER(a_last_only_data, out_valid && out_last && out_event != EV_DATA)

endmodule
